// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. All checks sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The check is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The check also holds in the cycles where reset is held.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/apdc_pkg.sv -----
package apdc_pkg;

  // Packet framing.
  localparam int PKT_LEN = 14;
  localparam int STORE_DEPTH = PKT_LEN - 1;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PKT_LEN - 1);
  localparam int BYTE_W = 8;
  localparam int ID_W = 16;

  // Channels and calibration.
  localparam int CH_NUM = 7;
  localparam int RAW_W = 12;
  localparam int DIFF_W = RAW_W + 1;
  localparam int CH_W = 27;
  localparam int VOLT_CH = 6;
  localparam int CUR_OFFSET = 2500;
  localparam int VOLT_OFFSET = 2380;
  localparam int FRAC_BITS_DEF = 16;

  // A completed packet as it waits for calibration.
  typedef struct packed {
    logic [ID_W-1:0]                   id;
    logic                              seq_err;
    logic [CH_NUM-1:0][RAW_W-1:0]      raw;
  } pkt_t;

endpackage

// ----- rtl/core/apdc_if.sv -----
// Byte request channel.
interface apdc_in_if;
  logic                         valid;
  logic                         ready;
  logic [apdc_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// Calibrated sample request channel.
interface apdc_out_if;
  logic                              valid;
  logic                              ready;
  logic [apdc_pkg::ID_W-1:0]         seq_id;
  logic                              sequence_error;
  logic signed [apdc_pkg::CH_W-1:0]  current_a;
  logic signed [apdc_pkg::CH_W-1:0]  current_b;
  logic signed [apdc_pkg::CH_W-1:0]  current_c;
  logic signed [apdc_pkg::CH_W-1:0]  current_d;
  logic signed [apdc_pkg::CH_W-1:0]  current_e;
  logic signed [apdc_pkg::CH_W-1:0]  current_f;
  logic signed [apdc_pkg::CH_W-1:0]  mains_voltage;

  modport source (output valid, output seq_id, output sequence_error,
                  output current_a, output current_b, output current_c,
                  output current_d, output current_e, output current_f,
                  output mains_voltage, input ready);
  modport sink (input valid, input seq_id, input sequence_error,
                input current_a, input current_b, input current_c,
                input current_d, input current_e, input current_f,
                input mains_voltage, output ready);
endinterface

// ----- rtl/core/apdc_cal.sv -----
// One channel of calibration: (raw - OFFSET) * GAIN, saturated to the field width.
module apdc_cal #(
  parameter int              FRAC_BITS = apdc_pkg::FRAC_BITS_DEF,
  parameter int              OFFSET    = apdc_pkg::CUR_OFFSET,
  parameter longint unsigned GAIN      = 64'd0
) (
  input  logic [apdc_pkg::RAW_W-1:0]        raw,
  output logic signed [apdc_pkg::CH_W-1:0]  value
);

  localparam int GAIN_W = FRAC_BITS + 1;
  localparam int PROD_W = apdc_pkg::DIFF_W + GAIN_W;
  localparam int EXT_W = (PROD_W > apdc_pkg::CH_W) ? PROD_W : apdc_pkg::CH_W;
  localparam logic signed [GAIN_W-1:0] GainS = GAIN_W'(GAIN);
  localparam logic signed [EXT_W-1:0] SatHi = EXT_W'((1 <<< (apdc_pkg::CH_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SatLo = -SatHi - EXT_W'(1);

  logic signed [apdc_pkg::DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0]           prod;
  logic signed [EXT_W-1:0]            prod_x;

  // Remove the offset, then scale by the fixed-point gain.
  assign diff   = $signed({1'b0, raw}) - apdc_pkg::DIFF_W'(OFFSET);
  assign prod   = PROD_W'(diff) * PROD_W'(GainS);
  assign prod_x = EXT_W'(prod);

  // Clamp to the signed output range.
  always_comb begin
    if (prod_x > SatHi) begin
      value = apdc_pkg::CH_W'(SatHi);
    end else if (prod_x < SatLo) begin
      value = apdc_pkg::CH_W'(SatLo);
    end else begin
      value = apdc_pkg::CH_W'(prod_x);
    end
  end

endmodule

// ----- rtl/core/adc_packet_deframer_calibrator_unit.sv -----
// Channel   | Dir | Payload                                          | Handshake
// ----------+-----+--------------------------------------------------+------------
// in_ch     | in  | data_byte[7:0]                                   | valid/ready
// out_ch    | out | seq_id, sequence_error, 7 x Q signed [26:0]      | valid/ready
// cfg       | in  | cfg_wdata = device_kind                          | cfg_we
//
// One byte is taken per cycle while in_ch.ready is high. The 14th byte of a packet
// fills the packet register, and the calibrated result passes from there into the
// output register once that register is free. The input stalls only while a
// finished packet waits behind an output that is held by out_ch.ready.
// Reset (rst_n low, synchronous) clears framing, sequence tracking, the halt flag
// and device_kind. After a sequence error every later byte is taken and dropped.
`include "assert_macros.svh"

module adc_packet_deframer_calibrator_unit #(
  parameter int FRAC_BITS = apdc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  apdc_in_if.sink           in_ch,
  apdc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  // Gains rounded to the nearest step of 2^-FRAC_BITS, halves up.
  localparam longint unsigned GainA =
    ((64'd15151515 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned GainB =
    ((64'd5405405 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned GainV =
    ((64'd2853 << FRAC_BITS) + 64'd5000) / 64'd10000;

  logic                              dev_kind_r;
  logic [apdc_pkg::POS_W-1:0]        byte_pos_r, byte_pos_nxt;
  logic [apdc_pkg::BYTE_W-1:0]       pkt_bytes_r [apdc_pkg::STORE_DEPTH];
  logic [apdc_pkg::ID_W-1:0]         prev_id_r, prev_id_nxt;
  logic                              seeded_r, seeded_nxt;
  logic                              halted_r, halted_nxt;

  logic                              s1_v_r, s1_v_nxt;
  apdc_pkg::pkt_t                    s1_pkt_r;
  apdc_pkg::pkt_t                    pkt_nxt;

  logic                              out_v_r, out_v_nxt;
  logic [apdc_pkg::ID_W-1:0]         out_id_r;
  logic                              out_err_r;
  logic signed [apdc_pkg::CH_W-1:0]  out_ch_r [apdc_pkg::CH_NUM];
  logic signed [apdc_pkg::CH_W-1:0]  cal_val [apdc_pkg::CH_NUM];

  logic                              in_fire;
  logic                              out_free;
  logic                              s1_adv;
  logic                              s1_load;
  logic                              is_last;

  // Handshake control.
  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_adv      = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_last     = (byte_pos_r == apdc_pkg::LAST_POS);
  assign s1_load     = in_fire && !halted_r && is_last;

  // Assemble the packet from the stored bytes and the closing byte.
  always_comb begin
    if (!dev_kind_r) begin
      pkt_nxt.id = {pkt_bytes_r[0], pkt_bytes_r[1]};
    end else begin
      pkt_nxt.id = {pkt_bytes_r[1], pkt_bytes_r[0]};
    end
    pkt_nxt.seq_err = seeded_r && (pkt_nxt.id != apdc_pkg::ID_W'(prev_id_r + 1'b1));
    for (int j = 0; j < apdc_pkg::CH_NUM; j++) begin
      pkt_nxt.raw[j][apdc_pkg::RAW_W-1] = in_ch.data_byte[j+1];
      for (int i = 2; i < apdc_pkg::STORE_DEPTH; i++) begin
        pkt_nxt.raw[j][i-2] = pkt_bytes_r[i][j+1];
      end
    end
  end

  // Framing and sequence tracking.
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    prev_id_nxt  = prev_id_r;
    seeded_nxt   = seeded_r;
    halted_nxt   = halted_r;
    if (in_fire && !halted_r) begin
      if (is_last) begin
        byte_pos_nxt = '0;
        if (pkt_nxt.seq_err) begin
          halted_nxt = 1'b1;
        end else begin
          seeded_nxt  = 1'b1;
          prev_id_nxt = pkt_nxt.id;
        end
      end else begin
        byte_pos_nxt = byte_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_kind_r <= 1'b0;
      byte_pos_r <= '0;
      prev_id_r  <= '0;
      seeded_r   <= 1'b0;
      halted_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        dev_kind_r <= cfg_wdata;
      end
      byte_pos_r <= byte_pos_nxt;
      prev_id_r  <= prev_id_nxt;
      seeded_r   <= seeded_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // Packet byte store, written at the current position.
  always_ff @(posedge clk) begin
    if (in_fire && !halted_r && !is_last) begin
      pkt_bytes_r[byte_pos_r] <= in_ch.data_byte;
    end
  end

  // Packet register between framing and calibration.
  assign s1_v_nxt = s1_load || (s1_v_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pkt_r <= pkt_nxt;
    end
  end

  // Per-channel calibration.
  for (genvar j = 0; j < apdc_pkg::CH_NUM; j++) begin : g_cal
    apdc_cal #(
      .FRAC_BITS (FRAC_BITS),
      .OFFSET    ((j == apdc_pkg::VOLT_CH) ? apdc_pkg::VOLT_OFFSET : apdc_pkg::CUR_OFFSET),
      .GAIN      ((j == 0) ? GainA : ((j == apdc_pkg::VOLT_CH) ? GainV : GainB))
    ) u_cal (
      .raw   (s1_pkt_r.raw[j]),
      .value (cal_val[j])
    );
  end

  // Result register; an error result carries zero channels.
  assign out_v_nxt = s1_adv || (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_id_r  <= s1_pkt_r.id;
      out_err_r <= s1_pkt_r.seq_err;
      for (int j = 0; j < apdc_pkg::CH_NUM; j++) begin
        out_ch_r[j] <= s1_pkt_r.seq_err ? '0 : cal_val[j];
      end
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.seq_id         = out_id_r;
  assign out_ch.sequence_error = out_err_r;
  assign out_ch.current_a      = out_ch_r[0];
  assign out_ch.current_b      = out_ch_r[1];
  assign out_ch.current_c      = out_ch_r[2];
  assign out_ch.current_d      = out_ch_r[3];
  assign out_ch.current_e      = out_ch_r[4];
  assign out_ch.current_f      = out_ch_r[5];
  assign out_ch.mains_voltage  = out_ch_r[6];

  // Checks.
  `ASSERT_CLK(a_no_pkt_when_halted, !(halted_r && s1_load), "packet formed while halted")
  `ASSERT_CLK(a_halt_after_err, (s1_load && pkt_nxt.seq_err) |=> halted_r, "error did not halt")
  `ASSERT_CLK(a_err_zero_ch, (out_v_r && out_err_r) |-> (out_ch_r[0] == '0 && out_ch_r[6] == '0), "error result has nonzero channels")
  `ASSERT_CLK(a_pos_range, byte_pos_r <= apdc_pkg::LAST_POS, "byte position out of range")

endmodule
